FILE: rtl/sttq_pkg.sv
// Shared types and constants for the sorted timer task queue.
// No dependencies; imported by the queue cell and the top level.
`default_nettype none
package sttq_pkg;

   localparam int ID_BITS  = 4;
   localparam int RUN_BITS = 16;
   localparam int CNT_BITS = 8;
   localparam int RUN_SHIFT = 4;
   localparam logic [CNT_BITS-1:0] WINDOW_RESET = 8'd24;

   // operation codes
   localparam logic [2:0] FN_POLL  = 3'd0;
   localparam logic [2:0] FN_START = 3'd1;
   localparam logic [2:0] FN_AGAIN = 3'd2;
   localparam logic [2:0] FN_FIT   = 3'd3;
   localparam logic [2:0] FN_STOP  = 3'd4;
   localparam logic [2:0] FN_RECORD = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DROP,
      ST_PLACE,
      ST_REPLY
   } st_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_DROP,
      CM_PLACE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type        mode;
      logic                 fit;
      logic [ID_BITS-1:0]   key_id;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/sorted_timer_task_queue.sv
// Sorted timer task queue: a row of queue cells plus per-task state.
// Result strobe: rsp_valid is high in the reply state, after the drop and place states.
// A new start is taken only while not busy: in the idle state or the reply state.
// Each request makes a drop pass and then a place pass through the cell row.
// Reset empties the queue, clears all per-task state and sets the window to 24.
// The receiver cannot stall: each result shows for one cycle on rsp_valid.
`default_nettype none
module sorted_timer_task_queue
   import sttq_pkg::*;
#(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [2:0]    req_func,
   input  wire logic [3:0]    req_task_req,
   input  wire logic [31:0]   req_now_ms,
   input  wire logic [15:0]   req_delay_ms,
   input  wire logic [31:0]   req_elapsed_us,
   output logic               rsp_valid,
   output logic               rsp_dispatched,
   output logic [3:0]         rsp_dispatched_task,
   output logic               rsp_task_running,
   output logic [31:0]        rsp_task_time,
   output logic [15:0]        rsp_task_run_time,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [1:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NT_USED = (NUM_TASKS < 16) ? NUM_TASKS : 16;
   localparam int IW      = (NT_USED > 1) ? $clog2(NT_USED) : 1;

   st_type state_ff, state_in;

   logic [2:0]           func_ff;
   logic [ID_BITS-1:0]   task_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [15:0]          delay_ff;
   logic [31:0]          elapsed_ff;
   logic [CNT_BITS-1:0]  window_ff;
   logic                 disp_ff;
   logic [ID_BITS-1:0]   disp_id_ff;

   logic                 flag_ff  [NT_USED];
   logic [TIME_BITS-1:0] ttime_ff [NT_USED];
   logic [RUN_BITS-1:0]  rmax_ff  [NT_USED];
   logic [CNT_BITS-1:0]  wcnt_ff  [NT_USED];

   logic                 cell_valid [NUM_TASKS];
   logic [ID_BITS-1:0]   cell_id    [NUM_TASKS];
   logic [TIME_BITS-1:0] cell_time  [NUM_TASKS];
   logic [TIME_BITS-1:0] cell_ins   [NUM_TASKS];
   logic                 hit_chain  [NUM_TASKS+1];

   cell_ctl_type         ctl;
   logic [TIME_BITS-1:0] key_time;
   logic [TIME_BITS-1:0] delay_t;
   logic [TIME_BITS-1:0] ins_time;
   logic                 task_ok;
   logic [IW-1:0]        idx;
   logic [IW-1:0]        hidx;
   logic                 head_due;
   logic                 full;
   logic                 do_pop;
   logic                 do_place;
   logic [RUN_BITS-1:0]  sample;
   logic [CNT_BITS-1:0]  cnt_next;
   logic                 take;
   logic                 cfg_wr;

   assign take     = start && !busy;
   assign task_ok  = 32'(task_ff) < NUM_TASKS;
   assign idx      = task_ff[IW-1:0];
   assign hidx     = cell_id[0][IW-1:0];
   assign delay_t  = TIME_BITS'(delay_ff);
   assign head_due = cell_valid[0] && (cell_time[0] <= now_ff);
   assign full     = cell_valid[NUM_TASKS-1];
   assign do_pop   = (func_ff == FN_POLL) && head_due;
   assign do_place = task_ok && (func_ff inside {FN_START, FN_AGAIN, FN_FIT}) && !full;
   assign sample   = RUN_BITS'(elapsed_ff >> RUN_SHIFT);
   assign cnt_next = wcnt_ff[idx] + 1'b1;

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   always_comb begin
      prdata = '0;
      if (paddr == 2'd0) begin
         prdata = 32'(window_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (cfg_wr && paddr == 2'd0) begin
         window_ff <= pwdata[CNT_BITS-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_DROP;
         ST_DROP:  state_in = ST_PLACE;
         ST_PLACE: state_in = ST_REPLY;
         ST_REPLY: state_in = start ? ST_DROP : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshake outputs
   always_comb begin
      busy      = (state_ff == ST_DROP) || (state_ff == ST_PLACE);
      rsp_valid = (state_ff == ST_REPLY);
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (take) begin
         func_ff    <= req_func;
         task_ff    <= req_task_req;
         now_ff     <= TIME_BITS'(req_now_ms);
         delay_ff   <= req_delay_ms;
         elapsed_ff <= req_elapsed_us;
      end
   end

   // drive the cell row
   always_comb begin
      ctl.mode   = CM_HOLD;
      ctl.fit    = (func_ff == FN_FIT);
      ctl.key_id = task_ff;
      key_time   = now_ff + delay_t;
      if (func_ff == FN_AGAIN && task_ok) begin
         key_time = ttime_ff[idx] + delay_t;
      end
      case (state_ff)
         ST_DROP: begin
            if (do_pop) begin
               ctl.mode   = CM_DROP;
               ctl.key_id = cell_id[0];
            end else if (task_ok &&
                         (func_ff inside {FN_START, FN_AGAIN, FN_FIT, FN_STOP})) begin
               ctl.mode = CM_DROP;
            end
         end
         ST_PLACE: begin
            if (do_place) ctl.mode = CM_PLACE;
         end
         default: ctl.mode = CM_HOLD;
      endcase
   end

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
      logic                 lv;
      logic [ID_BITS-1:0]   lid;
      logic [TIME_BITS-1:0] lt;
      logic                 rv;
      logic [ID_BITS-1:0]   rid;
      logic [TIME_BITS-1:0] rt;

      if (i == 0) begin : g_first
         assign lv  = 1'b1;
         assign lid = '0;
         assign lt  = now_ff;
      end else begin : g_mid
         assign lv  = cell_valid[i-1];
         assign lid = cell_id[i-1];
         assign lt  = cell_time[i-1];
      end
      if (i == NUM_TASKS-1) begin : g_last
         assign rv  = 1'b0;
         assign rid = '0;
         assign rt  = '0;
      end else begin : g_inner
         assign rv  = cell_valid[i+1];
         assign rid = cell_id[i+1];
         assign rt  = cell_time[i+1];
      end

      sttq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .key_time    (key_time),
         .window      (delay_t),
         .left_valid  (lv),
         .left_id     (lid),
         .left_time   (lt),
         .right_valid (rv),
         .right_id    (rid),
         .right_time  (rt),
         .hit_in      (hit_chain[i]),
         .hit_out     (hit_chain[i+1]),
         .ins_time    (cell_ins[i]),
         .valid       (cell_valid[i]),
         .id          (cell_id[i]),
         .time_q      (cell_time[i])
      );
   end

   // collect the due time chosen by the inserting cell
   always_comb begin
      ins_time = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         ins_time = ins_time | cell_ins[i];
      end
   end

   // per-task state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NT_USED; i++) begin
            flag_ff[i]  <= 1'b0;
            ttime_ff[i] <= '0;
            rmax_ff[i]  <= '0;
            wcnt_ff[i]  <= '0;
         end
      end else if (state_ff == ST_DROP) begin
         if (do_pop) begin
            flag_ff[hidx]  <= 1'b0;
            ttime_ff[hidx] <= now_ff;
         end else if (task_ok) begin
            if (func_ff inside {FN_START, FN_AGAIN, FN_FIT, FN_STOP}) begin
               flag_ff[idx] <= 1'b0;
            end else if (func_ff == FN_RECORD) begin
               if (cnt_next == window_ff) begin
                  wcnt_ff[idx] <= '0;
                  rmax_ff[idx] <= sample;
               end else begin
                  wcnt_ff[idx] <= cnt_next;
                  if (sample > rmax_ff[idx]) rmax_ff[idx] <= sample;
               end
            end
         end
      end else if (state_ff == ST_PLACE && do_place) begin
         flag_ff[idx]  <= 1'b1;
         ttime_ff[idx] <= ins_time;
      end
   end

   // dispatch report
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff    <= 1'b0;
         disp_id_ff <= '0;
      end else if (state_ff == ST_DROP) begin
         disp_ff    <= do_pop;
         disp_id_ff <= do_pop ? cell_id[0] : '0;
      end
   end

   // result beat
   always_comb begin
      rsp_dispatched      = disp_ff;
      rsp_dispatched_task = disp_id_ff;
      rsp_task_running    = 1'b0;
      rsp_task_time       = '0;
      rsp_task_run_time   = '0;
      if (task_ok) begin
         rsp_task_running  = flag_ff[idx];
         rsp_task_time     = 32'(ttime_ff[idx]);
         rsp_task_run_time = rmax_ff[idx];
      end
   end

   // checks
   logic [NUM_TASKS-1:0] vld_vec;
   logic [NT_USED-1:0]   flag_vec;
   always_comb begin
      for (int i = 0; i < NUM_TASKS; i++) vld_vec[i] = cell_valid[i];
      for (int i = 0; i < NT_USED; i++) flag_vec[i] = flag_ff[i];
   end

   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((vld_vec + 1'b1) & vld_vec) == '0)
      else $error("queue cells not packed at the head");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(flag_vec) == $countones(vld_vec)))
      else $error("task flags disagree with queue occupancy");

   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("accepted beat did not raise busy");

   a_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_PLACE)
      else $error("result beat without a place pass");

endmodule
`default_nettype wire

FILE: rtl/sttq_cell.sv
// One slot of the sorted queue: holds an entry, shifts with its neighbors.
// Depends on sttq_pkg for the control struct and id width.
`default_nettype none
module sttq_cell
   import sttq_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctl_type         ctl,
   input  wire logic [TIME_BITS-1:0] key_time,
   input  wire logic [TIME_BITS-1:0] window,
   input  wire logic                 left_valid,
   input  wire logic [ID_BITS-1:0]   left_id,
   input  wire logic [TIME_BITS-1:0] left_time,
   input  wire logic                 right_valid,
   input  wire logic [ID_BITS-1:0]   right_id,
   input  wire logic [TIME_BITS-1:0] right_time,
   input  wire logic                 hit_in,
   output logic                      hit_out,
   output logic [TIME_BITS-1:0]      ins_time,
   output logic                      valid,
   output logic [ID_BITS-1:0]        id,
   output logic [TIME_BITS-1:0]      time_q
);

   logic                 valid_ff, valid_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] new_time;
   logic [TIME_BITS-1:0] limit;
   logic                 self_hit;

   // local hit: matching id on drop, insertion point on place
   always_comb begin
      limit    = left_time + window;
      new_time = ctl.fit ? left_time : key_time;
      self_hit = 1'b0;
      case (ctl.mode)
         CM_DROP:  self_hit = valid_ff && (id_ff == ctl.key_id);
         CM_PLACE: self_hit = !valid_ff ||
                              (ctl.fit ? !(time_ff < limit) : (time_ff > key_time));
         default:  self_hit = 1'b0;
      endcase
      hit_out  = hit_in | self_hit;
      ins_time = (ctl.mode == CM_PLACE && self_hit && !hit_in) ?
                 new_time : '0;
   end

   // shift left on drop, shift right or load on place
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      time_in  = time_ff;
      case (ctl.mode)
         CM_DROP: begin
            if (hit_out) begin
               valid_in = right_valid;
               id_in    = right_id;
               time_in  = right_time;
            end
         end
         CM_PLACE: begin
            if (hit_in) begin
               valid_in = left_valid;
               id_in    = left_id;
               time_in  = left_time;
            end else if (self_hit) begin
               valid_in = 1'b1;
               id_in    = ctl.key_id;
               time_in  = new_time;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   assign valid  = valid_ff;
   assign id     = id_ff;
   assign time_q = time_ff;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for sorted_timer_task_queue: random and directed operations checked
// against an in-bench model of the sorted timer queue. Depends on rtl/sttq_pkg.sv.
`timescale 1ns / 100ps
module tb
   import sttq_pkg::*;
;

   localparam int NT = 16;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  task_id;
      logic [31:0] now_ms;
      logic [15:0] delay_ms;
      logic [31:0] elapsed_us;
   } op_t;

   typedef struct packed {
      logic        disp;
      logic [3:0]  disp_id;
      logic        running;
      logic [31:0] ttime;
      logic [15:0] run_max;
   } reply_t;

   // marker in the op queue: pause until drained, then write window
   typedef struct {
      bit          is_cfg;
      logic [7:0]  window;
      op_t         op;
   } pend_t;

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic [2:0] req_func = '0;
   logic [3:0] req_task_req = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_delay_ms = '0;
   logic [31:0] req_elapsed_us = '0;
   logic rsp_valid, rsp_dispatched, rsp_task_running;
   logic [3:0] rsp_dispatched_task;
   logic [31:0] rsp_task_time;
   logic [15:0] rsp_task_run_time;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sorted_timer_task_queue dut (.*);

   // model state
   logic [3:0]  q_ids [NT];
   logic [31:0] q_times [NT];
   int          q_len;
   logic        flags [NT];
   logic [31:0] last_times [NT];
   logic [15:0] maxima [NT];
   logic [7:0]  counts [NT];
   logic [7:0]  window_runs;

   pend_t  pending [$];
   reply_t expected_replies [$];
   int errors, mismatches, checked, dispatches, idle_cycles;
   int burst_left, gap_left;
   bit in_pause;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void model_reset();
      for (int i = 0; i < NT; i++) begin
         flags[i] = 0; last_times[i] = 0; maxima[i] = 0; counts[i] = 0;
      end
      q_len = 0;
      window_runs = WINDOW_RESET;
   endfunction

   function automatic void unqueue(int id);
      for (int i = 0; i < q_len; i++) begin
         if (q_ids[i] == id) begin
            for (int j = i; j + 1 < q_len; j++) begin
               q_ids[j] = q_ids[j+1]; q_times[j] = q_times[j+1];
            end
            q_len--;
            break;
         end
      end
      flags[id] = 0;
   endfunction

   function automatic void enqueue(int id, int pos, logic [31:0] due);
      if (q_len >= NT || pos > q_len) return;
      for (int j = q_len; j > pos; j--) begin
         q_ids[j] = q_ids[j-1]; q_times[j] = q_times[j-1];
      end
      q_ids[pos] = 4'(id); q_times[pos] = due;
      q_len++;
      flags[id] = 1; last_times[id] = due;
   endfunction

   function automatic void schedule(int id, logic [31:0] due);
      int pos;
      pos = 0;
      unqueue(id);
      while (pos < q_len && q_times[pos] <= due) pos++;
      enqueue(id, pos, due);
   endfunction

   // insert at the first gap at least as long as the window
   function automatic void fit_gap(int id, logic [31:0] now, logic [15:0] win);
      int pos;
      logic [31:0] t, lim;
      pos = 0;
      t = now;
      unqueue(id);
      lim = t + win;
      while (pos < q_len && q_times[pos] < lim) begin
         t = q_times[pos]; pos++; lim = t + win;
      end
      enqueue(id, pos, t);
   endfunction

   function automatic reply_t queue_step(op_t op);
      reply_t r;
      int id;
      logic [15:0] sample;
      r = '0;
      id = op.task_id;
      case (op.func)
         FN_POLL: begin
            if (q_len > 0 && q_times[0] <= op.now_ms) begin
               r.disp_id = q_ids[0];
               unqueue(q_ids[0]);
               last_times[r.disp_id] = op.now_ms;
               r.disp = 1;
            end
         end
         FN_START: schedule(id, op.now_ms + op.delay_ms);
         FN_AGAIN: schedule(id, last_times[id] + op.delay_ms);
         FN_FIT:   fit_gap(id, op.now_ms, op.delay_ms);
         FN_STOP:  unqueue(id);
         FN_RECORD: begin
            sample = op.elapsed_us[19:4];
            counts[id] = counts[id] + 8'd1;
            if (counts[id] == window_runs) begin
               counts[id] = 0; maxima[id] = sample;
            end else if (sample > maxima[id]) maxima[id] = sample;
         end
         default: ;
      endcase
      r.running = flags[id];
      r.ttime = last_times[id];
      r.run_max = maxima[id];
      return r;
   endfunction

   // times cluster near a base so compares and ties happen often
   logic [31:0] time_base;
   function automatic op_t rand_op(bit noisy);
      op_t o;
      o.func = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      if (!noisy && $urandom_range(0, 2) == 0) o.func = FN_POLL;
      o.task_id = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: o.now_ms = $urandom;
         default: o.now_ms = time_base + $urandom_range(0, 300);
      endcase
      o.delay_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
      o.elapsed_us = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 4000);
      return o;
   endfunction

   function automatic void push_op(op_t o);
      pend_t p;
      p.is_cfg = 0; p.window = 0; p.op = o;
      pending.push_back(p);
   endfunction

   function automatic void push_cfg(logic [7:0] w);
      pend_t p;
      p.is_cfg = 1; p.window = w; p.op = '0;
      pending.push_back(p);
   endfunction

   function automatic op_t mk(logic [2:0] f, logic [3:0] t, logic [31:0] n,
                              logic [15:0] d, logic [31:0] e);
      op_t o;
      o.func = f; o.task_id = t; o.now_ms = n; o.delay_ms = d; o.elapsed_us = e;
      return o;
   endfunction

   // fill stimulus: directed first, then random phases with window changes
   initial begin
      logic [7:0] windows [6];
      windows = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd24};
      time_base = 32'd1000;
      push_op(mk(FN_POLL, 0, 0, 0, 0));
      push_op(mk(FN_START, 0, 100, 10, 0));
      push_op(mk(FN_START, 1, 100, 10, 0));
      push_op(mk(FN_START, 2, 32'hFFFF_FFF0, 16'hFFFF, 0));
      push_op(mk(FN_FIT, 3, 100, 5, 0));
      push_op(mk(FN_FIT, 4, 100, 0, 0));
      push_op(mk(FN_START, 0, 100, 20, 0));
      push_op(mk(FN_POLL, 9, 50, 0, 0));
      push_op(mk(FN_POLL, 9, 110, 0, 0));
      push_op(mk(FN_POLL, 9, 32'hFFFF_FFFF, 0, 0));
      push_op(mk(FN_AGAIN, 1, 0, 16'hFFFF, 0));
      push_op(mk(FN_STOP, 1, 0, 0, 0));
      push_op(mk(FN_STOP, 5, 0, 0, 0));
      push_op(mk(FN_RECORD, 15, 0, 0, 32'hFFFF_FFFF));
      push_op(mk(FN_RECORD, 15, 0, 0, 0));
      push_op(mk(FN_RECORD, 15, 0, 0, 32'h0010_0000));
      push_op(mk(3'd6, 2, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555));
      push_op(mk(3'd7, 7, 32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA));
      for (int i = 0; i < 16; i++) push_op(mk(FN_START, 4'(i), 500, 16'(i[1:0]), 0));
      push_op(mk(FN_FIT, 3, 400, 16'd2, 0));
      for (int ph = 0; ph < 6; ph++) begin
         push_cfg(windows[ph]);
         for (int k = 0; k < 105; k++) begin
            if ($urandom_range(0, 40) == 0) time_base = $urandom;
            else time_base = time_base + $urandom_range(0, 40);
            push_op(rand_op(k % 10 == 9));
         end
      end
   end

   // driver: bursts and gaps; config writes only once drained
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (in_pause) begin
         start <= 0;
      end else if (start && busy) begin
         // hold the beat until taken
      end else if (psel && !penable) begin
         penable <= 1;
      end else if (psel && penable) begin
         psel <= 0; penable <= 0; pwrite <= 0;
         start <= 0;
      end else if (pending.size() == 0) begin
         start <= 0;
      end else if (pending[0].is_cfg) begin
         start <= 0;
         if (expected_replies.size() == 0 && !busy) begin
            window_runs = pending[0].window;
            psel <= 1; pwrite <= 1; paddr <= 2'd0;
            pwdata <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, pending[0].window};
            void'(pending.pop_front());
         end
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 0;
      end else begin
         req_func <= pending[0].op.func;
         req_task_req <= pending[0].op.task_id;
         req_now_ms <= pending[0].op.now_ms;
         req_delay_ms <= pending[0].op.delay_ms;
         req_elapsed_us <= pending[0].op.elapsed_us;
         start <= 1;
         if (burst_left > 0) burst_left--;
         else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // monitor: take beats and results on the rising edge
   always @(posedge clock) begin
      reply_t got, exp_r;
      bit active;
      active = 0;
      if (!reset) begin
         if (start && !busy) begin
            op_t o;
            o = {req_func, req_task_req, req_now_ms, req_delay_ms, req_elapsed_us};
            void'(pending.pop_front());
            expected_replies.push_back(queue_step(o));
            active = 1;
            // pause once mid-run until all results are back
            if (pending.size() == 300) in_pause = 1;
         end
         if (in_pause && expected_replies.size() == 0 && !rsp_valid) in_pause = 0;
         if (psel && penable && pwrite && pready) active = 1;
         if (rsp_valid) begin
            active = 1;
            got = {rsp_dispatched, rsp_dispatched_task, rsp_task_running,
                   rsp_task_time, rsp_task_run_time};
            if (expected_replies.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected result %h", got);
            end else begin
               exp_r = expected_replies.pop_front();
               checked++;
               if (got.disp) dispatches++;
               if (got !== exp_r) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch %0d: disp %b/%b id %0d/%0d run %b/%b time %h/%h max %h/%h",
                              checked, exp_r.disp, got.disp, exp_r.disp_id, got.disp_id,
                              exp_r.running, got.running, exp_r.ttime, got.ttime,
                              exp_r.run_max, got.run_max);
               end
            end
         end
         idle_cycles <= active ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      model_reset();
      errors = 0; mismatches = 0; checked = 0; dispatches = 0; idle_cycles = 0;
      burst_left = 0; gap_left = 0; in_pause = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      while ((pending.size() > 0 || expected_replies.size() > 0) && idle_cycles < WATCHDOG)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: timeout, %0d results outstanding", expected_replies.size());
         $display("tb: done, errors");
      end else begin
         $display("tb: %0d results checked, %0d dispatches, six window settings",
                  checked, dispatches);
         if (errors == 0 && expected_replies.size() == 0) $display("tb: done, clean");
         else $display("tb: done, errors");
      end
      $finish;
   end
endmodule
